// ===== rtl/tree_fanout_peer_select_top_macros.svh =====
// Assertion macros for the tree fan-out peer selection block.
// Taken in by the modules that carry concurrent assertions; no dependencies.
`ifndef TREE_FANOUT_PEER_SELECT_TOP_MACROS_SVH
`define TREE_FANOUT_PEER_SELECT_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TFPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfps assertion failed");

// Next-cycle implication, disabled in reset.
`define TFPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfps assertion failed");

`endif

// ===== rtl/tfps_pkg.sv =====
// Types and constants shared by the tree fan-out peer selection block.
// No dependencies.
package tfps_pkg;

    localparam int NODE_W = 6;
    localparam int CFG_W  = 7;

    typedef enum logic [1:0] {
        CFG_TREE_WIDTH   = 2'd0,
        CFG_NODE_COUNT   = 2'd1,
        CFG_OWN_INDEX    = 2'd2,
        CFG_CHILD_OFFSET = 2'd3
    } t_cfg_idx;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SETUP  = 8'b0000_0010,
        S_WALK   = 8'b0000_0100,
        S_POPLD  = 8'b0000_1000,
        S_ASTART = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_ACHK   = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] child;
    } t_stk_entry;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] addr;
        t_stk_entry        entry;
    } t_stk_wr;

endpackage

// ===== rtl/tfps_stack.sv =====
// Walk stack storage: entries below the top of the depth-first stack.
// One write port, one registered read port. Depends on tfps_pkg.
module tfps_stack (
    input  logic                            i_clk,
    input  tfps_pkg::t_stk_wr               i_wr,
    input  logic [tfps_pkg::NODE_W-1:0]     i_raddr,
    output tfps_pkg::t_stk_entry            o_rdata
);

    localparam int DEPTH = 1 << tfps_pkg::NODE_W;

    tfps_pkg::t_stk_entry r_mem [DEPTH];
    tfps_pkg::t_stk_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tree_fanout_peer_select_top.sv =====
// Top level of the tree fan-out peer selection block: sequencer, shared
// multiply unit, result staging. Depends on tfps_pkg, tfps_stack and the macro header.
//
// A request (start while not busy) takes a 64-bit connected-peer mask; the block
// then walks the implicit k-ary tree one step a cycle, apart from the stack reload
// after a pop, with a single small multiplier, node*width + child + 1, and climbs
// ancestors with a restoring divide that reuses the same multiplier. Busy stays
// high through setup, the walk and the ancestor climb, until the final result.
// Results are held one deep so that last can be set, and each appears for a
// single cycle on o_valid: the receiver cannot stall, so it must take every
// result as it comes.
`include "tree_fanout_peer_select_top_macros.svh"

module tree_fanout_peer_select_top #(
    parameter int MAX_NODES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [tfps_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_start,
    input  logic [63:0]                   i_peer_mask,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic [tfps_pkg::NODE_W-1:0]   o_node_index,
    output logic                          o_found,
    output logic                          o_last
);

    localparam logic [6:0] LP_MAX = 7'(MAX_NODES);

    // configuration
    logic [6:0] r_tree_width;
    logic [6:0] r_node_count;
    logic [6:0] r_own_index;
    logic [5:0] r_child_offset;

    // sequencer
    tfps_pkg::t_state     r_state, n_state;
    logic [63:0]          r_mask, n_mask;
    logic [6:0]           r_sp, n_sp;
    tfps_pkg::t_stk_entry r_top, n_top;
    logic [5:0]           r_div_d, n_div_d;
    logic [5:0]           r_quo, n_quo;
    logic [2:0]           r_bit, n_bit;

    // result staging
    logic       r_pend_vld;
    logic [5:0] r_pend_idx;
    logic [6:0] r_emit_cnt;

    logic                 emit;
    logic [5:0]           emit_idx;
    logic                 fin;
    logic                 accept;
    tfps_pkg::t_stk_wr    stk_wr;
    logic [5:0]           stk_raddr;
    tfps_pkg::t_stk_entry stk_rdata;

    logic [6:0]  w_eff;
    logic [6:0]  n_eff;
    logic        absent;
    logic [5:0]  own;
    logic [5:0]  trial;
    logic [5:0]  mul_a;
    logic [12:0] prod;
    logic [13:0] e_idx;
    logic [6:0]  q_idx;
    logic        pop_cond;
    logic [6:0]  sp_m1;
    logic [6:0]  sp_m2;
    logic [5:0]  child_inc;

    assign accept = i_start && (r_state == tfps_pkg::S_IDLE);
    assign o_busy = (r_state != tfps_pkg::S_IDLE);

    assign w_eff  = (r_tree_width == 7'd0) ? 7'd1 : r_tree_width;
    assign n_eff  = (r_node_count > LP_MAX) ? LP_MAX : r_node_count;
    assign absent = r_own_index[6];
    assign own    = r_own_index[5:0];

    // shared multiplier: child index in the walk, trial product in the divide
    assign trial = r_quo | (6'd1 << r_bit);
    assign mul_a = (r_state == tfps_pkg::S_DIV) ? trial : r_top.node;
    assign prod  = 13'(mul_a) * 13'(w_eff);

    assign e_idx     = {1'b0, prod} + 14'(r_top.child) + 14'd1;
    assign q_idx     = {1'b0, e_idx[5:0]} + {1'b0, r_child_offset};
    assign pop_cond  = ({1'b0, r_top.child} >= w_eff) || (e_idx >= 14'(n_eff));
    assign sp_m1     = r_sp - 7'd1;
    assign sp_m2     = r_sp - 7'd2;
    assign child_inc = r_top.child + 6'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_width   <= 7'd3;
            r_node_count   <= 7'd0;
            r_own_index    <= 7'h7F;
            r_child_offset <= 6'd0;
        end else if (i_cfg_we) begin
            case (tfps_pkg::t_cfg_idx'(i_cfg_idx))
                tfps_pkg::CFG_TREE_WIDTH:   r_tree_width   <= i_cfg_data;
                tfps_pkg::CFG_NODE_COUNT:   r_node_count   <= i_cfg_data;
                tfps_pkg::CFG_OWN_INDEX:    r_own_index    <= i_cfg_data;
                tfps_pkg::CFG_CHILD_OFFSET: r_child_offset <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_mask    = r_mask;
        n_sp      = r_sp;
        n_top     = r_top;
        n_div_d   = r_div_d;
        n_quo     = r_quo;
        n_bit     = r_bit;
        emit      = 1'b0;
        emit_idx  = 6'd0;
        fin       = 1'b0;
        stk_wr    = '0;
        stk_raddr = 6'd0;
        case (r_state)
            tfps_pkg::S_IDLE: begin
                if (i_start) begin
                    n_mask  = i_peer_mask;
                    n_sp    = 7'd0;
                    n_state = tfps_pkg::S_SETUP;
                end
            end
            tfps_pkg::S_SETUP: begin
                if (absent) begin
                    if (n_eff != 7'd0 && r_mask[0]) begin
                        emit    = 1'b1;
                        n_state = tfps_pkg::S_FIN;
                    end else if (n_eff == 7'd0) begin
                        n_state = tfps_pkg::S_FIN;
                    end else begin
                        n_top   = '{node: 6'd0, child: 6'd0};
                        n_sp    = 7'd1;
                        n_state = tfps_pkg::S_WALK;
                    end
                end else if ({1'b0, own} < n_eff) begin
                    n_top   = '{node: own, child: 6'd0};
                    n_sp    = 7'd1;
                    n_state = tfps_pkg::S_WALK;
                end else begin
                    n_state = tfps_pkg::S_ASTART;
                end
            end
            tfps_pkg::S_WALK: begin
                if (pop_cond) begin
                    n_sp = sp_m1;
                    if (r_sp == 7'd1) begin
                        n_state = absent ? tfps_pkg::S_FIN : tfps_pkg::S_ASTART;
                    end else begin
                        stk_raddr = sp_m2[5:0];
                        n_state   = tfps_pkg::S_POPLD;
                    end
                end else begin
                    n_top.child = child_inc;
                    if (r_mask[e_idx[5:0]]) begin
                        emit     = 1'b1;
                        emit_idx = e_idx[5:0];
                    end else if (q_idx < n_eff && r_sp < 7'd64) begin
                        stk_wr.we    = 1'b1;
                        stk_wr.addr  = sp_m1[5:0];
                        stk_wr.entry = '{node: r_top.node, child: child_inc};
                        n_top        = '{node: q_idx[5:0], child: 6'd0};
                        n_sp         = r_sp + 7'd1;
                    end
                end
            end
            tfps_pkg::S_POPLD: begin
                n_top   = stk_rdata;
                n_state = tfps_pkg::S_WALK;
            end
            tfps_pkg::S_ASTART: begin
                if (own == 6'd0) begin
                    n_state = tfps_pkg::S_FIN;
                end else begin
                    n_div_d = own - 6'd1;
                    n_quo   = 6'd0;
                    n_bit   = 3'd5;
                    n_state = tfps_pkg::S_DIV;
                end
            end
            tfps_pkg::S_DIV: begin
                if (prod <= 13'(r_div_d)) begin
                    n_quo = trial;
                end
                if (r_bit == 3'd0) begin
                    n_state = tfps_pkg::S_ACHK;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            tfps_pkg::S_ACHK: begin
                if ({1'b0, r_quo} < n_eff && r_mask[r_quo]) begin
                    emit     = 1'b1;
                    emit_idx = r_quo;
                    n_state  = tfps_pkg::S_FIN;
                end else if (r_quo == 6'd0) begin
                    n_state = tfps_pkg::S_FIN;
                end else begin
                    n_div_d = r_quo - 6'd1;
                    n_quo   = 6'd0;
                    n_bit   = 3'd5;
                    n_state = tfps_pkg::S_DIV;
                end
            end
            tfps_pkg::S_FIN: begin
                fin     = 1'b1;
                n_state = tfps_pkg::S_IDLE;
            end
            default: begin
                n_state = tfps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfps_pkg::S_IDLE;
            r_sp    <= 7'd0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
        end
        r_mask  <= n_mask;
        r_top   <= n_top;
        r_div_d <= n_div_d;
        r_quo   <= n_quo;
        r_bit   <= n_bit;
    end

    // one-deep staging so that the final transaction carries last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_emit_cnt <= 7'd0;
        end else begin
            o_valid <= 1'b0;
            if (accept) begin
                r_pend_vld <= 1'b0;
                r_emit_cnt <= 7'd0;
            end
            if (emit && r_emit_cnt < LP_MAX) begin
                if (r_pend_vld) begin
                    o_valid      <= 1'b1;
                    o_node_index <= r_pend_idx;
                    o_found      <= 1'b1;
                    o_last       <= 1'b0;
                end
                r_pend_idx <= emit_idx;
                r_pend_vld <= 1'b1;
                r_emit_cnt <= r_emit_cnt + 7'd1;
            end
            if (fin) begin
                o_valid      <= 1'b1;
                o_node_index <= r_pend_vld ? r_pend_idx : 6'd0;
                o_found      <= r_pend_vld;
                o_last       <= 1'b1;
                r_pend_vld   <= 1'b0;
            end
        end
    end

    tfps_stack u_stack (
        .i_clk   (i_clk),
        .i_wr    (stk_wr),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    `TFPS_ASSERT_IMP(a_last_ends_busy, i_clk, i_rst_n, o_valid && o_last, !o_busy)
    `TFPS_ASSERT_IMP(a_more_keeps_busy, i_clk, i_rst_n, o_valid && !o_last, o_busy)
    `TFPS_ASSERT_IMP(a_empty_is_single, i_clk, i_rst_n, o_valid && !o_found, o_last)
    `TFPS_ASSERT_IMP(a_sp_bound, i_clk, i_rst_n, 1'b1, r_sp <= 7'd64)
    `TFPS_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)

endmodule
